>>> rtl/core/dost_pkg.sv
// Package: shared constants and types of the dual-order span table.
`default_nettype none
package dost_pkg;
  localparam int unsigned Depth = 64;
  localparam int unsigned SlotW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpDelete = 2'd1;
  localparam logic [1:0] OpSeekStart = 2'd2;
  localparam logic [1:0] OpSeekEnd = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] start;
    logic [15:0] span_end;
    logic [7:0]  kind;
    logic [15:0] sortn;
  } span_t;
endpackage
`default_nettype wire

>>> rtl/core/dost_cmp.sv
// Module: shared order comparator, probe entry less than key.
`default_nettype none
module dost_cmp (
  input  dost_pkg::span_t probe_i,
  input  dost_pkg::span_t key_i,
  input  logic            by_end_i,
  input  logic [7:0]      format_kind_i,
  output logic            less_o
);
  import dost_pkg::*;
  always_comb begin
    if (!by_end_i) begin
      if (probe_i.start != key_i.start) less_o = probe_i.start < key_i.start;
      else if (probe_i.span_end != key_i.span_end) less_o = probe_i.span_end > key_i.span_end;
      else if (probe_i.kind != key_i.kind) less_o = probe_i.kind < key_i.kind;
      else if (probe_i.kind == format_kind_i && probe_i.sortn != key_i.sortn)
        less_o = probe_i.sortn < key_i.sortn;
      else less_o = probe_i.id < key_i.id;
    end else begin
      if (probe_i.span_end != key_i.span_end) less_o = probe_i.span_end < key_i.span_end;
      else if (probe_i.start != key_i.start) less_o = probe_i.start > key_i.start;
      else if (probe_i.kind != key_i.kind) less_o = probe_i.kind > key_i.kind;
      else if (probe_i.kind == format_kind_i && probe_i.sortn != key_i.sortn)
        less_o = probe_i.sortn > key_i.sortn;
      else less_o = probe_i.id > key_i.id;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/dual_order_sorted_span_table.sv
// Top level: sorted span table kept in start order and end order.
// Seek: binary search, each probe in steps: index, read order, read entry, compare.
// Insert: two seeks, then a read and a write per moved order element in each order.
// Delete: linear end-order scan plus shifts, a read and a check per scanned element, a read and a write per shift.
// Result held in an output register; next item taken while it waits, one item at a time.
// Reset clears count, free map and format kind; stores stay undefined until written.
`default_nettype none
module dual_order_sorted_span_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] item_id_i,
  input  logic [15:0] span_start_i,
  input  logic [15:0] span_end_i,
  input  logic [7:0]  kind_i,
  input  logic [15:0] sort_number_i,
  input  logic [5:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [6:0]  result_position_o,
  output logic [6:0]  entry_count_o,
  output logic [1:0]  status_o
);
  import dost_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PROBE, S_ORD_RD, S_ENT_RD, S_CMP, S_SEEK_DONE,
    S_INS_SLOT, S_SH_RD, S_SH_WR, S_DEL_RD, S_DSCAN_RD, S_DSCAN_CK,
    S_DEL_SH_RD, S_DEL_SH_WR, S_FINISH
  } state_e;

  state_e state_q;
  logic [7:0] fmt_q;
  logic [Depth-1:0] free_q;
  logic [CntW-1:0] cnt_q;
  span_t key_q;
  logic [1:0] op_q;
  logic [SlotW-1:0] pos_q;
  logic pass_q;
  logic signed [CntW:0] lo_q, hi_q, mid_q;
  logic hit1_q;
  logic [CntW-1:0] p1_q, p2_q;
  logic [SlotW-1:0] slot_q;
  logic [CntW-1:0] idx_q;
  logic [SlotW-1:0] rd_q;
  logic [SlotW-1:0] dslot_q;

  span_t ent_mem [Depth];
  logic [SlotW-1:0] so_mem [Depth];
  logic [SlotW-1:0] eo_mem [Depth];

  logic found_q;
  logic [6:0] rpos_q;
  logic [1:0] stat_q;

  logic out_v_q, res_found_q;
  logic [6:0] res_rpos_q, res_cnt_q;
  logic [1:0] res_stat_q;

  span_t probe_q;
  logic less;
  logic [SlotW-1:0] low_free;
  logic [CntW-1:0] ptgt;
  logic [SlotW-1:0] rd_addr;
  logic ord_we;
  logic [SlotW-1:0] ord_wdata;
  logic res_load;

  dost_cmp u_cmp (
    .probe_i(probe_q), .key_i(key_q), .by_end_i(pass_q),
    .format_kind_i(fmt_q), .less_o(less)
  );

  always_comb begin
    low_free = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (free_q[i]) low_free = SlotW'(i);
    end
  end

  always_comb begin
    case (state_q)
      S_SH_RD: rd_addr = SlotW'(idx_q - 1'b1);
      S_DEL_SH_RD: rd_addr = SlotW'(idx_q + 1'b1);
      default: rd_addr = idx_q[SlotW-1:0];
    endcase
  end

  assign ptgt = pass_q ? p2_q : p1_q;
  assign ord_we = (state_q == S_SH_RD && idx_q == ptgt) || state_q == S_SH_WR ||
                  state_q == S_DEL_SH_WR;
  assign ord_wdata = (state_q == S_SH_RD) ? slot_q : rd_q;
  assign res_load = (state_q == S_FINISH) && (!out_v_q || out_ready_i);

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign found_o = res_found_q;
  assign result_position_o = res_rpos_q;
  assign entry_count_o = res_cnt_q;
  assign status_o = res_stat_q;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (state_q == S_ORD_RD || state_q == S_SH_RD || state_q == S_DSCAN_RD ||
        state_q == S_DEL_SH_RD) begin
      rd_q <= pass_q ? eo_mem[rd_addr] : so_mem[rd_addr];
    end
    if (state_q == S_DEL_RD) dslot_q <= so_mem[rd_addr];
    if (state_q == S_ENT_RD) probe_q <= ent_mem[rd_q];
    if (state_q == S_INS_SLOT) ent_mem[slot_q] <= key_q;
    if (ord_we) begin
      if (pass_q) eo_mem[idx_q[SlotW-1:0]] <= ord_wdata;
      else so_mem[idx_q[SlotW-1:0]] <= ord_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fmt_q <= '0;
      free_q <= '1;
      cnt_q <= '0;
      out_v_q <= 1'b0;
      res_found_q <= 1'b0;
      res_rpos_q <= '0;
      res_cnt_q <= '0;
      res_stat_q <= StOk;
      pass_q <= 1'b0;
    end else begin
      if (cfg_we_i) fmt_q <= cfg_wdata_i;
      if (res_load) begin
        out_v_q <= 1'b1;
        res_found_q <= found_q;
        res_rpos_q <= rpos_q;
        res_cnt_q <= 7'(cnt_q);
        res_stat_q <= stat_q;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            key_q <= '{item_id_i, span_start_i, span_end_i, kind_i, sort_number_i};
            op_q <= operation_i;
            pos_q <= position_i;
            found_q <= 1'b0;
            rpos_q <= (operation_i == OpDelete) ? 7'(position_i) : 7'd0;
            lo_q <= '0;
            hi_q <= $signed({1'b0, cnt_q} - 1'b1);
            pass_q <= (operation_i == OpSeekEnd);
            case (operation_i)
              OpInsert: begin
                if (cnt_q >= CntW'(Depth)) begin
                  stat_q <= StFull;
                  state_q <= S_FINISH;
                end else begin
                  stat_q <= StOk;
                  state_q <= S_PROBE;
                end
              end
              OpDelete: begin
                if (CntW'(position_i) >= cnt_q) begin
                  stat_q <= StRange;
                  state_q <= S_FINISH;
                end else begin
                  stat_q <= StOk;
                  idx_q <= CntW'(position_i);
                  state_q <= S_DEL_RD;
                end
              end
              default: begin
                stat_q <= StOk;
                state_q <= S_PROBE;
              end
            endcase
          end
        end
        S_PROBE: begin
          if (lo_q <= hi_q) begin
            mid_q <= lo_q + ((hi_q - lo_q) >>> 1);
            idx_q <= CntW'(lo_q + ((hi_q - lo_q) >>> 1));
            state_q <= S_ORD_RD;
          end else begin
            hit1_q <= 1'b0;
            state_q <= S_SEEK_DONE;
          end
        end
        S_ORD_RD: state_q <= S_ENT_RD;
        S_ENT_RD: state_q <= S_CMP;
        S_CMP: begin
          if (probe_q.id == key_q.id) begin
            lo_q <= mid_q;
            hit1_q <= 1'b1;
            state_q <= S_SEEK_DONE;
          end else if (less) begin
            lo_q <= mid_q + $signed(2'b01);
            state_q <= S_PROBE;
          end else if (mid_q == 0) begin
            hit1_q <= 1'b0;
            state_q <= S_SEEK_DONE;
          end else begin
            hi_q <= mid_q - $signed(2'b01);
            state_q <= S_PROBE;
          end
        end
        S_SEEK_DONE: begin
          if (op_q != OpInsert) begin
            found_q <= hit1_q;
            rpos_q <= 7'(lo_q);
            state_q <= S_FINISH;
          end else if (!pass_q) begin
            p1_q <= CntW'(lo_q);
            rpos_q <= 7'(lo_q);
            found_q <= hit1_q;
            pass_q <= 1'b1;
            lo_q <= '0;
            hi_q <= $signed({1'b0, cnt_q} - 1'b1);
            state_q <= S_PROBE;
          end else if (found_q || hit1_q) begin
            found_q <= 1'b0;
            state_q <= S_FINISH;
          end else begin
            p2_q <= CntW'(lo_q);
            slot_q <= low_free;
            pass_q <= 1'b0;
            idx_q <= cnt_q;
            state_q <= S_INS_SLOT;
          end
        end
        S_INS_SLOT: begin
          free_q[slot_q] <= 1'b0;
          state_q <= S_SH_RD;
        end
        S_SH_RD: begin
          if (idx_q == ptgt) begin
            if (!pass_q) begin
              pass_q <= 1'b1;
              idx_q <= cnt_q;
            end else begin
              pass_q <= 1'b0;
              cnt_q <= cnt_q + 1'b1;
              found_q <= 1'b1;
              state_q <= S_FINISH;
            end
          end else begin
            state_q <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          idx_q <= idx_q - 1'b1;
          state_q <= S_SH_RD;
        end
        S_DEL_RD: begin
          idx_q <= '0;
          pass_q <= 1'b1;
          state_q <= S_DSCAN_RD;
        end
        S_DSCAN_RD: state_q <= S_DSCAN_CK;
        S_DSCAN_CK: begin
          if (rd_q == dslot_q) begin
            p2_q <= idx_q;
            state_q <= S_DEL_SH_RD;
          end else if (idx_q + 1'b1 >= cnt_q) begin
            pass_q <= 1'b0;
            idx_q <= CntW'(pos_q);
            state_q <= S_DEL_SH_RD;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_DSCAN_RD;
          end
        end
        S_DEL_SH_RD: begin
          if (idx_q + 1'b1 >= cnt_q) begin
            if (pass_q) begin
              pass_q <= 1'b0;
              idx_q <= CntW'(pos_q);
            end else begin
              free_q[dslot_q] <= 1'b1;
              cnt_q <= cnt_q - 1'b1;
              found_q <= 1'b1;
              state_q <= S_FINISH;
            end
          end else begin
            state_q <= S_DEL_SH_WR;
          end
        end
        S_DEL_SH_WR: begin
          idx_q <= idx_q + 1'b1;
          state_q <= S_DEL_SH_RD;
        end
        S_FINISH: begin
          if (res_load) begin
            pass_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // hold result until transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q && $stable(res_rpos_q))
    else $error("result dropped before transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(~free_q) == 32'(cnt_q) || state_q != S_IDLE)
    else $error("free map and count disagree");
endmodule
`default_nettype wire
